@@ hw/rtl/mhrt_pkg.sv @@
// Shared types and constants of the minimum-hop route table.
package mhrt_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] FN_ADD    = 2'd0;
    localparam logic [1:0] FN_DELETE = 2'd1;
    localparam logic [1:0] FN_LOOKUP = 2'd2;
    localparam logic [1:0] FN_NONE   = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_PRESENT  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;
    localparam logic [2:0] ST_FOUND    = 3'd5;
    localparam logic [2:0] ST_NOROUTE  = 3'd6;
    localparam logic [2:0] ST_DELETED  = 3'd7;

    // Routes at or above this hop count are never chosen by a lookup.
    localparam logic [7:0] HOP_LIMIT = 8'd128;

    // Saturation value of the delete count.
    localparam logic [4:0] RM_MAX = 5'd31;

    // One table entry; a neighbor of zero marks a free entry.
    typedef struct packed {
        logic [7:0] nb;
        logic [7:0] dst;
        logic [7:0] hops;
    } entry_t;

    // Ring control handed from the head unit to the cells.
    typedef struct packed {
        logic   shift;
        entry_t head;
    } ring_ctl_t;

endpackage

@@ hw/rtl/mhrt_cell.sv @@
// One storage cell of the route table ring.
module mhrt_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            shift,
    input  mhrt_pkg::entry_t d_in,
    output mhrt_pkg::entry_t q
);
    import mhrt_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        entry_next = shift ? d_in : entry_reg;
    end

    // The table is all free after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign q = entry_reg;

endmodule

@@ hw/rtl/mhrt_head.sv @@
// Head unit: sequencer, per-entry operation logic and the result register.
module mhrt_head #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_func,
    input  logic [7:0]          s_neighbor,
    input  logic [7:0]          s_destination,
    input  logic [7:0]          s_hop_count,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic [7:0]          m_best_neighbor,
    output logic [6:0]          m_best_hops,
    output logic [4:0]          m_removed_count,
    input  mhrt_pkg::entry_t    ring_q,
    output mhrt_pkg::ring_ctl_t ring_ctl
);
    import mhrt_pkg::*;

    localparam int CNT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(TABLE_ENTRIES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       op_reg, op_next;
    logic [7:0]       nb_reg, nb_next;
    logic [7:0]       dst_reg, dst_next;
    logic [7:0]       hops_reg, hops_next;
    logic             found_reg, found_next;
    logic             free_seen_reg, free_seen_next;
    logic [CNT_W-1:0] free_idx_reg, free_idx_next;
    logic [7:0]       best_reg, best_next;
    logic [7:0]       via_reg, via_next;
    logic [4:0]       rm_reg, rm_next;
    logic [2:0]       res_status_reg, res_status_next;

    logic             m_valid_reg, m_valid_next;
    logic [2:0]       m_status_reg, m_status_next;
    logic [7:0]       m_best_neighbor_reg, m_best_neighbor_next;
    logic [6:0]       m_best_hops_reg, m_best_hops_next;
    logic [4:0]       m_removed_count_reg, m_removed_count_next;

    entry_t head_out;
    logic   last;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign last    = (cnt_reg == LAST_IDX);

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        nb_next         = nb_reg;
        dst_next        = dst_reg;
        hops_next       = hops_reg;
        found_next      = found_reg;
        free_seen_next  = free_seen_reg;
        free_idx_next   = free_idx_reg;
        best_next       = best_reg;
        via_next        = via_reg;
        rm_next         = rm_reg;
        res_status_next = res_status_reg;
        head_out        = ring_q;

        m_valid_next         = m_valid_reg && !m_ready;
        m_status_next        = m_status_reg;
        m_best_neighbor_next = m_best_neighbor_reg;
        m_best_hops_next     = m_best_hops_reg;
        m_removed_count_next = m_removed_count_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next        = s_func;
                    nb_next        = s_neighbor;
                    dst_next       = s_destination;
                    hops_next      = s_hop_count;
                    cnt_next       = '0;
                    found_next     = 1'b0;
                    free_seen_next = 1'b0;
                    free_idx_next  = '0;
                    best_next      = HOP_LIMIT;
                    via_next       = '0;
                    rm_next        = '0;
                    if (s_func == FN_NONE) begin
                        state_next = S_IDLE;
                    end else if (s_func != FN_LOOKUP && s_neighbor == 8'd0) begin
                        res_status_next = ST_INVALID;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                unique case (op_reg)
                    FN_ADD: begin
                        if (!found_reg && ring_q.nb == nb_reg && ring_q.dst == dst_reg) begin
                            found_next      = 1'b1;
                            head_out.hops   = hops_reg;
                            res_status_next = (ring_q.hops == hops_reg) ? ST_PRESENT
                                                                         : ST_UPDATED;
                        end
                        if (!free_seen_reg && ring_q.nb == 8'd0) begin
                            free_seen_next = 1'b1;
                            free_idx_next  = cnt_reg;
                        end
                    end
                    FN_DELETE: begin
                        if (ring_q.nb == nb_reg) begin
                            head_out = '0;
                            if (rm_reg != RM_MAX) begin
                                rm_next = rm_reg + 5'd1;
                            end
                        end
                    end
                    default: begin
                        if (ring_q.nb != 8'd0 && ring_q.dst == dst_reg
                                && ring_q.hops < best_reg) begin
                            best_next = ring_q.hops;
                            via_next  = ring_q.nb;
                        end
                    end
                endcase
                cnt_next = cnt_reg + CNT_W'(1);
                if (last) begin
                    cnt_next = '0;
                    unique case (op_reg)
                        FN_ADD: begin
                            if (found_next) begin
                                state_next = S_DONE;
                            end else if (free_seen_next) begin
                                state_next = S_FILL;
                            end else begin
                                res_status_next = ST_FULL;
                                state_next      = S_DONE;
                            end
                        end
                        FN_DELETE: begin
                            res_status_next = ST_DELETED;
                            state_next      = S_DONE;
                        end
                        default: begin
                            res_status_next = (via_next != 8'd0) ? ST_FOUND : ST_NOROUTE;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_FILL: begin
                if (cnt_reg == free_idx_reg) begin
                    head_out.nb   = nb_reg;
                    head_out.dst  = dst_reg;
                    head_out.hops = hops_reg;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (last) begin
                    cnt_next        = '0;
                    res_status_next = ST_INSERTED;
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_status_next        = res_status_reg;
                    m_best_neighbor_next = via_reg;
                    m_best_hops_next     = best_reg[6:0] & {7{via_reg != 8'd0}};
                    m_removed_count_next = rm_reg;
                    state_next           = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg              <= op_next;
        nb_reg              <= nb_next;
        dst_reg             <= dst_next;
        hops_reg            <= hops_next;
        found_reg           <= found_next;
        free_seen_reg       <= free_seen_next;
        free_idx_reg        <= free_idx_next;
        best_reg            <= best_next;
        via_reg             <= via_next;
        rm_reg              <= rm_next;
        res_status_reg      <= res_status_next;
        m_status_reg        <= m_status_next;
        m_best_neighbor_reg <= m_best_neighbor_next;
        m_best_hops_reg     <= m_best_hops_next;
        m_removed_count_reg <= m_removed_count_next;
    end

    assign ring_ctl.shift   = (state_reg == S_SCAN) || (state_reg == S_FILL);
    assign ring_ctl.head    = head_out;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_best_neighbor  = m_best_neighbor_reg;
    assign m_best_hops      = m_best_hops_reg;
    assign m_removed_count  = m_removed_count_reg;

endmodule

@@ hw/rtl/min_hop_route_table_unit.sv @@
// Top level of the minimum-hop route table: a ring of entry cells and its head unit.
//
// Usage: each item on the s_ channel carries one operation (add or update a route,
// delete all routes of a neighbor, or look up the best next hop for a destination).
// Every add, delete or lookup yields exactly one result item on the m_ channel;
// operation code three is accepted and dropped without a result.
// The entries sit in a ring of TABLE_ENTRIES cells. While an operation runs, the
// ring rotates by one entry per cycle, so the entries pass the head unit in index order
// during a pass and the table is back in its original order after a full pass.
// Sequence: a lookup, a delete, or an add that finds its pair or finds the table full,
// takes one pass of the ring and then loads the result register; the next item is
// taken once the head unit is back in idle.
// An add that inserts into a free entry needs a second pass to write the entry.
// An add or delete with neighbor zero answers without a pass.
// The rotating ring sets the length of a pass: one entry per cycle at the head.
// The input is accepted only while the head unit is idle. A finished result waits
// in the output register; if the receiver stalls, the next item may be accepted
// and processed, and its result is held back until the output register is free.
// Synchronous active-low reset empties every entry and drops any pending result.
module min_hop_route_table_unit #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [7:0] s_neighbor,
    input  logic [7:0] s_destination,
    input  logic [7:0] s_hop_count,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [7:0] m_best_neighbor,
    output logic [6:0] m_best_hops,
    output logic [4:0] m_removed_count
);
    import mhrt_pkg::*;

    // Cell k feeds cell k-1; the head unit reads cell 0 and feeds the last cell.
    entry_t    cell_q [TABLE_ENTRIES];
    ring_ctl_t ring_ctl;

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        entry_t cell_d;
        if (k == TABLE_ENTRIES - 1) begin : g_tail
            assign cell_d = ring_ctl.head;
        end else begin : g_link
            assign cell_d = cell_q[k+1];
        end
        mhrt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift   (ring_ctl.shift),
            .d_in    (cell_d),
            .q       (cell_q[k])
        );
    end

    mhrt_head #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_head (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_neighbor      (s_neighbor),
        .s_destination   (s_destination),
        .s_hop_count     (s_hop_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_best_neighbor (m_best_neighbor),
        .m_best_hops     (m_best_hops),
        .m_removed_count (m_removed_count),
        .ring_q          (cell_q[0]),
        .ring_ctl        (ring_ctl)
    );

    // An operation that yields a result keeps the input closed in the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_func != FN_NONE) |=> !s_ready)
        else $error("input accepted again right after an operation began");

    // The ring only rotates while an operation is in progress.
    a_no_shift_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !ring_ctl.shift)
        else $error("ring rotated while the head unit was idle");

    // A found route always names a neighbor; every other result carries no neighbor or hops.
    a_found_has_hop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FOUND) |-> (m_best_neighbor != 8'd0))
        else $error("lookup reported found without a next hop");

    a_noroute_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_FOUND)
            |-> (m_best_neighbor == 8'd0 && m_best_hops == 7'd0))
        else $error("route fields set on a result that is not a found lookup");

    // Only a delete reports cleared entries.
    a_removed_only_delete: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_removed_count != 5'd0) |-> (m_status == ST_DELETED))
        else $error("removed count set on a result that is not a delete");

endmodule
